// File: hw/rtl/nib_pkg.sv
// Shared constants and types for the router input buffer.
// No dependencies; every other file in hw/rtl imports it.
package nib_pkg;

  localparam int NIB_DEPTH   = 16;
  localparam int NIB_FLIT_W  = 32;

  // Occupancy at which credit turns back on.
  localparam int NIB_CREDIT_ON_OCC = 2;

  // Handshake bits of one registered beat, read by the control logic.
  typedef struct packed {
    logic rx_valid;
    logic route_ack;
    logic send_ack;
  } nib_beat_ctl_t;

  // Buffer port controls driven by the control logic.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } nib_buf_ctl_t;

endpackage

// File: hw/rtl/nib_in_reg.sv
// Input register stage: captures one beat and holds it until it is processed.
// Depends on nib_pkg.
module nib_in_reg #(
  parameter int FLIT_WIDTH = nib_pkg::NIB_FLIT_W
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_rx_valid,
  input  logic [FLIT_WIDTH-1:0] in_flit_in,
  input  logic                  in_flit_in_tail,
  input  logic                  in_route_ack,
  input  logic                  in_send_ack,
  input  logic                  adv,
  output logic                  beat_valid,
  output nib_pkg::nib_beat_ctl_t beat_ctl,
  output logic [FLIT_WIDTH-1:0] beat_flit,
  output logic                  beat_tail
);
  import nib_pkg::*;

  logic                  valid_r, valid_nxt;
  nib_beat_ctl_t         ctl_r;
  logic [FLIT_WIDTH-1:0] flit_r;
  logic                  tail_r;
  logic                  take;

  assign in_stall = valid_r && !adv;
  assign take     = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (adv) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ctl_r.rx_valid  <= in_rx_valid;
      ctl_r.route_ack <= in_route_ack;
      ctl_r.send_ack  <= in_send_ack;
      flit_r          <= in_flit_in;
      tail_r          <= in_flit_in_tail;
    end
  end

  assign beat_valid = valid_r;
  assign beat_ctl   = ctl_r;
  assign beat_flit  = flit_r;
  assign beat_tail  = tail_r;

endmodule

// File: hw/rtl/nib_buf.sv
// Circular flit store with per-entry valid bits and a registered head word.
// Depends on nib_pkg.
module nib_buf #(
  parameter int DEPTH      = nib_pkg::NIB_DEPTH,
  parameter int FLIT_WIDTH = nib_pkg::NIB_FLIT_W,
  parameter int PTR_W      = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  nib_pkg::nib_buf_ctl_t buf_ctl,
  input  logic [PTR_W-1:0]      wr_addr,
  input  logic [PTR_W-1:0]      rd_addr,
  input  logic [FLIT_WIDTH-1:0] wr_flit,
  input  logic                  wr_tail,
  output logic [FLIT_WIDTH-1:0] head_flit,
  output logic                  head_tail
);
  import nib_pkg::*;

  logic [FLIT_WIDTH:0] mem [DEPTH];
  logic [DEPTH-1:0]    ent_valid_r;
  logic [FLIT_WIDTH:0] head_r;
  logic [FLIT_WIDTH:0] wr_word;

  assign wr_word = {wr_tail, wr_flit};

  always_ff @(posedge clk) begin
    if (buf_ctl.wr_en) begin
      mem[wr_addr] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_valid_r <= '0;
    end else if (buf_ctl.wr_en) begin
      ent_valid_r[wr_addr] <= 1'b1;
    end
  end

  // Head word tracks the entry at the read pointer; bypass a same-edge write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
    end else if (buf_ctl.rd_en) begin
      if (buf_ctl.wr_en && (wr_addr == rd_addr)) begin
        head_r <= wr_word;
      end else if (ent_valid_r[rd_addr]) begin
        head_r <= mem[rd_addr];
      end else begin
        head_r <= '0;
      end
    end
  end

  assign head_flit = head_r[FLIT_WIDTH-1:0];
  assign head_tail = head_r[FLIT_WIDTH];

endmodule

// File: hw/rtl/nib_ctrl.sv
// Pointers, credit control and the wormhole send state machine.
// Depends on nib_pkg.
module nib_ctrl #(
  parameter int DEPTH = nib_pkg::NIB_DEPTH,
  parameter int PTR_W = $clog2(DEPTH)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   beat_valid,
  input  nib_pkg::nib_beat_ctl_t beat_ctl,
  input  logic                   head_tail,
  input  logic                   out_stall,
  output logic                   out_valid,
  output logic                   adv,
  output nib_pkg::nib_buf_ctl_t  buf_ctl,
  output logic [PTR_W-1:0]       wr_addr,
  output logic [PTR_W-1:0]       rd_addr,
  output logic                   credit,
  output logic                   route_req,
  output logic                   avail,
  output logic                   sending
);
  import nib_pkg::*;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_HEADER  = 3'd1;
  localparam logic [2:0] ST_SENDHDR = 3'd2;
  localparam logic [2:0] ST_PAYLOAD = 3'd3;
  localparam logic [2:0] ST_END     = 3'd4;
  localparam logic [2:0] ST_END2    = 3'd5;

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [PTR_W:0]   DEPTH_C  = (PTR_W+1)'(DEPTH);
  localparam logic [PTR_W:0]   OCC_FULL2 = (PTR_W+1)'(DEPTH - 2);
  localparam logic [PTR_W:0]   OCC_FULL1 = (PTR_W+1)'(DEPTH - 1);
  localparam logic [PTR_W:0]   OCC_ON    = (PTR_W+1)'(NIB_CREDIT_ON_OCC);

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  logic [PTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt, rp_inc;
  logic [2:0]       state_r, state_nxt;
  logic             space_r, space_nxt;
  logic             req_r, req_nxt;
  logic             avail_r, avail_nxt;
  logic             sending_r, sending_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [PTR_W:0]   occ;
  logic             nonempty;
  logic             wr_en;

  assign adv      = beat_valid && (!out_valid_r || !out_stall);
  assign nonempty = (rp_r != wp_r);
  assign rp_inc   = ptr_inc(rp_r);
  assign occ      = (wp_r >= rp_r) ? ({1'b0, wp_r} - {1'b0, rp_r})
                                   : ({1'b0, wp_r} + DEPTH_C - {1'b0, rp_r});
  assign wr_en    = adv && space_r && beat_ctl.rx_valid;

  always_comb begin
    wp_nxt      = wp_r;
    rp_nxt      = rp_r;
    state_nxt   = state_r;
    space_nxt   = space_r;
    req_nxt     = req_r;
    avail_nxt   = avail_r;
    sending_nxt = sending_r;
    if (adv) begin
      if ((occ == OCC_FULL2) || (occ == OCC_FULL1)) begin
        space_nxt = 1'b0;
      end else if (occ == OCC_ON) begin
        space_nxt = 1'b1;
      end
      if (wr_en) begin
        wp_nxt = ptr_inc(wp_r);
      end
      case (state_r)
        ST_HEADER: begin
          if (beat_ctl.route_ack) begin
            state_nxt   = ST_SENDHDR;
            req_nxt     = 1'b0;
            avail_nxt   = 1'b1;
            sending_nxt = 1'b1;
          end
        end
        ST_SENDHDR: begin
          if (beat_ctl.send_ack) begin
            rp_nxt    = rp_inc;
            avail_nxt = (rp_inc != wp_r);
            state_nxt = ST_PAYLOAD;
          end
        end
        ST_PAYLOAD: begin
          if (beat_ctl.send_ack && nonempty && !head_tail) begin
            rp_nxt    = rp_inc;
            avail_nxt = (rp_inc != wp_r);
          end else if (beat_ctl.send_ack && nonempty && head_tail) begin
            rp_nxt      = rp_inc;
            avail_nxt   = 1'b0;
            sending_nxt = 1'b0;
            state_nxt   = ST_END;
          end else if (nonempty) begin
            avail_nxt = 1'b1;
          end
        end
        ST_END: begin
          avail_nxt = 1'b0;
          state_nxt = ST_END2;
        end
        ST_END2: begin
          avail_nxt = 1'b0;
          state_nxt = ST_IDLE;
        end
        default: begin
          avail_nxt = 1'b0;
          req_nxt   = nonempty;
          state_nxt = nonempty ? ST_HEADER : ST_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      rp_r        <= '0;
      state_r     <= ST_IDLE;
      space_r     <= 1'b1;
      req_r       <= 1'b0;
      avail_r     <= 1'b0;
      sending_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      state_r     <= state_nxt;
      space_r     <= space_nxt;
      req_r       <= req_nxt;
      avail_r     <= avail_nxt;
      sending_r   <= sending_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign buf_ctl.wr_en = wr_en;
  assign buf_ctl.rd_en = adv;
  assign wr_addr       = wp_r;
  assign rd_addr       = rp_nxt;
  assign credit        = space_r;
  assign route_req     = req_r;
  assign avail         = avail_r;
  assign sending       = sending_r;
  assign out_valid     = out_valid_r;

  a_req_not_sending: assert property (@(posedge clk) disable iff (!rst_n)
    !(req_r && sending_r))
    else $error("route request raised during a transfer");

  a_avail_in_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    avail_r |-> sending_r)
    else $error("flit offered outside a transfer");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (!avail_r && !sending_r))
    else $error("idle state with flit offered or transfer flag set");

  a_route_grant: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && (state_r == ST_HEADER) && beat_ctl.route_ack)
      |=> (avail_r && sending_r && (state_r == ST_SENDHDR)))
    else $error("route grant did not start the header send");

  a_no_write_off_credit: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> space_r)
    else $error("buffer written without credit");

endmodule

// File: hw/rtl/noc_input_buffer_credit_fsm.sv
// Router input port: flit buffer, credit control and wormhole send FSM.
// An accepted beat waits in the input register until the result side can take
//   its result; it is then processed into the flag registers and head word.
// Throughput: one beat per cycle while out_stall is low, as pointers, FSM and
//   the registered head word of the flit store all update together.
// Reset (rst_n, synchronous, active low): pointers zero, FSM idle, credit on,
//   flags low, every store entry reads as zero through its cleared valid bit.
module noc_input_buffer_credit_fsm #(
  parameter int DEPTH      = nib_pkg::NIB_DEPTH,
  parameter int FLIT_WIDTH = nib_pkg::NIB_FLIT_W
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel: each beat carries a sample of the link and switch signals
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_rx_valid,
  input  logic [FLIT_WIDTH-1:0] in_flit_in,
  input  logic                  in_flit_in_tail,
  input  logic                  in_route_ack,
  input  logic                  in_send_ack,
  // result channel: the port's outputs after that beat
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_credit_out,
  output logic                  out_route_request,
  output logic                  out_flit_available,
  output logic [FLIT_WIDTH-1:0] out_flit_out,
  output logic                  out_flit_out_tail,
  output logic                  out_sending
);
  import nib_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);

  logic                  beat_valid;
  nib_beat_ctl_t         beat_ctl;
  logic [FLIT_WIDTH-1:0] beat_flit;
  logic                  beat_tail;
  logic                  adv;
  nib_buf_ctl_t          buf_ctl;
  logic [PTR_W-1:0]      wr_addr;
  logic [PTR_W-1:0]      rd_addr;
  logic                  head_tail;

  // Hold the incoming beat; it frees up as soon as the result side can take
  // the next result, so a result held by out_stall blocks acceptance.
  nib_in_reg #(
    .FLIT_WIDTH (FLIT_WIDTH)
  ) u_in_reg (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_valid     (in_rx_valid),
    .in_flit_in      (in_flit_in),
    .in_flit_in_tail (in_flit_in_tail),
    .in_route_ack    (in_route_ack),
    .in_send_ack     (in_send_ack),
    .adv             (adv),
    .beat_valid      (beat_valid),
    .beat_ctl        (beat_ctl),
    .beat_flit       (beat_flit),
    .beat_tail       (beat_tail)
  );

  // Advance pointers, credit and the send FSM; its flag registers are the
  // result beat's control fields.
  nib_ctrl #(
    .DEPTH (DEPTH),
    .PTR_W (PTR_W)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .beat_valid (beat_valid),
    .beat_ctl   (beat_ctl),
    .head_tail  (head_tail),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .adv        (adv),
    .buf_ctl    (buf_ctl),
    .wr_addr    (wr_addr),
    .rd_addr    (rd_addr),
    .credit     (out_credit_out),
    .route_req  (out_route_request),
    .avail      (out_flit_available),
    .sending    (out_sending)
  );

  // Store arriving flits; the head word follows the updated read pointer and
  // drives both the flit output and the tail mark the FSM checks on the next processed beat.
  nib_buf #(
    .DEPTH      (DEPTH),
    .FLIT_WIDTH (FLIT_WIDTH),
    .PTR_W      (PTR_W)
  ) u_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .buf_ctl   (buf_ctl),
    .wr_addr   (wr_addr),
    .rd_addr   (rd_addr),
    .wr_flit   (beat_flit),
    .wr_tail   (beat_tail),
    .head_flit (out_flit_out),
    .head_tail (head_tail)
  );

  assign out_flit_out_tail = head_tail;

endmodule
